/* hdl/sid_pkg.sv */
// shared types and constants for the signed integer divider
`timescale 1ns / 1ps

package sid_pkg;

   // operand and quotient width
   localparam int DivWidth = 32;
   // input register, one stage per quotient bit, output register
   localparam int DivLatency = DivWidth + 2;

   typedef logic [DivWidth-1:0] word_type;

   localparam word_type MinValue = {1'b1, {(DivWidth-1){1'b0}}};
   localparam word_type MaxValue = {1'b0, {(DivWidth-1){1'b1}}};
   localparam word_type AllOnes  = {DivWidth{1'b1}};
   localparam word_type ZeroWord = {DivWidth{1'b0}};

   // one item in flight through the divide pipeline
   typedef struct packed {
      logic     valid;
      word_type rem;   // partial remainder
      word_type acc;   // dividend bits still to come, quotient bits shifted in
      word_type den;   // divisor magnitude
      logic     neg;   // quotient is negative
      logic     dbz;   // divisor was zero
      logic     ovf;   // most negative over minus one
   } stage_type;

endpackage

/* hdl/sid_prep.sv */
// input stage: sign stripping and special case detection
`timescale 1ns / 1ps

module sid_prep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic signed [sid_pkg::DivWidth-1:0] dividend,
   input  logic signed [sid_pkg::DivWidth-1:0] divisor,
   output sid_pkg::stage_type              prep_out
);
   import sid_pkg::*;

   stage_type prep_ff;
   stage_type prep_in;
   logic      a_neg;
   logic      b_neg;
   word_type  a_word;
   word_type  b_word;

   // magnitudes, flags and sign of the quotient
   always_comb begin
      a_word = word_type'(dividend);
      b_word = word_type'(divisor);
      a_neg  = a_word[DivWidth-1];
      b_neg  = b_word[DivWidth-1];
      prep_in.valid = accept;
      prep_in.rem   = ZeroWord;
      prep_in.acc   = a_neg ? (ZeroWord - a_word) : a_word;
      prep_in.den   = b_neg ? (ZeroWord - b_word) : b_word;
      prep_in.neg   = a_neg ^ b_neg;
      prep_in.dbz   = (b_word == ZeroWord);
      prep_in.ovf   = (a_word == MinValue) && (b_word == AllOnes);
   end

   // stage register, valid cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else begin
         prep_ff <= prep_in;
      end
   end

   assign prep_out = prep_ff;

endmodule

/* hdl/sid_stage.sv */
// one restoring divide step: produces one quotient bit per stage
`timescale 1ns / 1ps

module sid_stage (
   input  logic               clock,
   input  logic               reset,
   input  sid_pkg::stage_type stage_in_data,
   output sid_pkg::stage_type stage_out_data
);
   import sid_pkg::*;

   stage_type             stage_ff;
   stage_type             stage_in;
   logic [DivWidth:0]     shifted;
   logic [DivWidth+1:0]   diff;
   logic                  take;

   // shift in the next dividend bit and trial subtract
   always_comb begin
      shifted  = {stage_in_data.rem, stage_in_data.acc[DivWidth-1]};
      diff     = {1'b0, shifted} - {2'b00, stage_in_data.den};
      take     = ~diff[DivWidth+1];
      stage_in = stage_in_data;
      stage_in.rem = take ? diff[DivWidth-1:0] : shifted[DivWidth-1:0];
      stage_in.acc = {stage_in_data.acc[DivWidth-2:0], take};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out_data = stage_ff;

endmodule

/* hdl/sid_fix.sv */
// output stage: sign reapplied, special cases substituted
`timescale 1ns / 1ps

module sid_fix (
   input  logic                                clock,
   input  logic                                reset,
   input  sid_pkg::stage_type                  fix_in,
   output logic                                rsp_valid,
   output logic signed [sid_pkg::DivWidth-1:0] rsp_quotient,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_overflow
);
   import sid_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   word_type quotient_ff;
   word_type quotient_in;
   logic     dbz_ff;
   logic     ovf_ff;

   // final quotient selection
   always_comb begin
      valid_in = fix_in.valid;
      if (fix_in.dbz) begin
         quotient_in = ZeroWord;
      end else if (fix_in.ovf) begin
         quotient_in = MaxValue;
      end else if (fix_in.neg) begin
         quotient_in = ZeroWord - fix_in.acc;
      end else begin
         quotient_in = fix_in.acc;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
      dbz_ff      <= fix_in.dbz;
      ovf_ff      <= fix_in.ovf & ~fix_in.dbz;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_quotient       = quotient_ff;
   assign rsp_divide_by_zero = dbz_ff;
   assign rsp_overflow       = ovf_ff;

endmodule

/* hdl/signed_integer_divider.sv */
// top level of the pipelined signed integer divider
`timescale 1ns / 1ps

// Signed 32-bit divider, quotient truncated toward zero. A transfer is taken
// whenever start is high; busy is always low, so a new division can start in
// every cycle. Each result appears on the rsp_ ports for one cycle, marked by
// rsp_valid, once it has passed one input register, 32 restoring subtract
// stages (one quotient bit each) and one output register.
// The results come out in the order the divisions went in. A zero divisor
// gives quotient 0 with rsp_divide_by_zero set; the most negative value
// divided by -1 gives the largest positive value with rsp_overflow set.

module signed_integer_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sid_pkg::DivWidth-1:0] req_dividend,
   input  logic signed [sid_pkg::DivWidth-1:0] req_divisor,
   output logic                                rsp_valid,
   output logic signed [sid_pkg::DivWidth-1:0] rsp_quotient,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_overflow
);
   import sid_pkg::*;

   stage_type chain [DivWidth+1];

   // the pipeline never stalls
   assign busy = 1'b0;

   // input stage
   sid_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (start & ~busy),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .prep_out (chain[0])
   );

   // one stage per quotient bit
   for (genvar i = 0; i < DivWidth; i++) begin : g_step
      sid_stage u_stage (
         .clock          (clock),
         .reset          (reset),
         .stage_in_data  (chain[i]),
         .stage_out_data (chain[i+1])
      );
   end

   // output stage
   sid_fix u_fix (
      .clock              (clock),
      .reset              (reset),
      .fix_in             (chain[DivWidth]),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflow       (rsp_overflow)
   );

   // the two error flags exclude each other
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_divide_by_zero && rsp_overflow))
      else $error("divide by zero and overflow both set");

   // a zero divisor yields a zero quotient
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == ZeroWord))
      else $error("nonzero quotient on divide by zero");

   // overflow saturates to the largest positive value
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_quotient == MaxValue))
      else $error("overflow quotient not saturated");

   // the most negative quotient only arises from a plain division
   a_min_quot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_quotient == MinValue) |->
         (!rsp_divide_by_zero && !rsp_overflow))
      else $error("most negative quotient with an error flag");

endmodule

/* bench/testbench.sv */
// self-checking testbench for the pipelined signed integer divider
`timescale 1ns / 1ps

module testbench;
   import sid_pkg::*;

   // cycles with no transfer on either side before the run is abandoned
   localparam int StallLimit = 1000;
   localparam int RandomDivisions = 630;
   localparam int PhaseCount = 4;

   // one division waiting to be driven
   typedef struct {
      word_type    dividend;
      word_type    divisor;
      int unsigned idle_pct;   // chance of an idle cycle before this transfer
      bit          drain;      // hold off until every quotient is back
   } division_type;

   // one quotient still owed by the block
   typedef struct {
      word_type dividend;
      word_type divisor;
      word_type quotient;
      logic     divide_by_zero;
      logic     overflow;
   } quotient_entry_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   word_type req_dividend = ZeroWord;
   word_type req_divisor = ZeroWord;
   logic     rsp_valid;
   word_type rsp_quotient;
   logic     rsp_divide_by_zero;
   logic     rsp_overflow;

   division_type       division_queue[$];
   quotient_entry_type quotient_queue[$];
   int                 divisions_in_flight = 0;
   int                 mismatch_count = 0;
   int                 stall_cycles = 0;

   signed_integer_divider dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflow       (rsp_overflow)
   );

   always #5 clock = ~clock;

   // quotient truncated toward zero by restoring division of the magnitudes
   function automatic quotient_entry_type divide_truncated(word_type a, word_type b);
      quotient_entry_type r;
      word_type           a_mag;
      word_type           b_mag;
      word_type           q_mag;
      logic [DivWidth:0]  rem;
      logic               a_neg;
      logic               b_neg;
      r.dividend = a;
      r.divisor = b;
      r.quotient = ZeroWord;
      r.divide_by_zero = 1'b0;
      r.overflow = 1'b0;
      a_neg = a[DivWidth-1];
      b_neg = b[DivWidth-1];
      a_mag = a_neg ? ZeroWord - a : a;
      b_mag = b_neg ? ZeroWord - b : b;
      if (b == ZeroWord) begin
         r.divide_by_zero = 1'b1;
      end else if (a == MinValue && b == AllOnes) begin
         // most negative over minus one saturates
         r.quotient = MaxValue;
         r.overflow = 1'b1;
      end else begin
         rem = '0;
         q_mag = ZeroWord;
         for (int i = DivWidth - 1; i >= 0; i--) begin
            rem = {rem[DivWidth-1:0], a_mag[i]};
            q_mag = q_mag << 1;
            if (rem >= {1'b0, b_mag}) begin
               rem = rem - {1'b0, b_mag};
               q_mag[0] = 1'b1;
            end
         end
         r.quotient = (a_neg != b_neg) ? ZeroWord - q_mag : q_mag;
      end
      return r;
   endfunction

   // operand drawn from a mix of full-range, small, boundary and shifted values
   function automatic word_type random_operand();
      int unsigned pick;
      word_type    v;
      pick = $urandom_range(99);
      if (pick < 40) begin
         v = $urandom;
      end else if (pick < 55) begin
         v = $urandom_range(16);
         if ($urandom_range(1)) v = ZeroWord - v;
      end else if (pick < 65) begin
         case ($urandom_range(4))
            0: v = MinValue;
            1: v = MaxValue;
            2: v = AllOnes;
            3: v = word_type'(1);
            default: v = ZeroWord;
         endcase
      end else if (pick < 75) begin
         v = word_type'(1) << $urandom_range(DivWidth - 1);
         if ($urandom_range(1)) v = ZeroWord - v;
      end else begin
         v = word_type'($urandom) >> $urandom_range(DivWidth - 1);
         if ($urandom_range(1)) v = ZeroWord - v;
      end
      return v;
   endfunction

   task automatic add_division(word_type a, word_type b, int unsigned idle_pct, bit drain);
      division_type d;
      d.dividend = a;
      d.divisor = b;
      d.idle_pct = idle_pct;
      d.drain = drain;
      division_queue.push_back(d);
   endtask

   task automatic report_mismatch(string what, quotient_entry_type want);
      $display("ERROR %s: %0d / %0d expected q=%0d dbz=%b ovf=%b got q=%0d dbz=%b ovf=%b",
               what, $signed(want.dividend), $signed(want.divisor),
               $signed(want.quotient), want.divide_by_zero, want.overflow,
               $signed(rsp_quotient), rsp_divide_by_zero, rsp_overflow);
      mismatch_count++;
   endtask

   // driver: present the next queued division after each transfer or idle cycle
   always @(posedge clock) begin : drive_proc
      logic         taken;
      division_type next_div;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (start && !taken) begin
            // block busy, hold the request
         end else if (division_queue.size() == 0) begin
            start <= 1'b0;
         end else if (division_queue[0].drain && (divisions_in_flight != 0 || taken)) begin
            start <= 1'b0;
         end else if ($urandom_range(99) < division_queue[0].idle_pct) begin
            start <= 1'b0;
         end else begin
            next_div = division_queue.pop_front();
            req_dividend <= next_div.dividend;
            req_divisor <= next_div.divisor;
            start <= 1'b1;
         end
      end
   end

   // monitor: check each result strobe, then record the division just accepted
   always @(posedge clock) begin : check_proc
      quotient_entry_type want;
      int                 delta;
      if (!reset) begin
         delta = 0;
         if (rsp_valid) begin
            if (quotient_queue.size() == 0) begin
               want = '{default: '0};
               report_mismatch("result with nothing outstanding", want);
            end else begin
               want = quotient_queue.pop_front();
               delta = delta - 1;
               if (rsp_quotient !== want.quotient)
                  report_mismatch("quotient", want);
               if (rsp_divide_by_zero !== want.divide_by_zero)
                  report_mismatch("divide_by_zero", want);
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", want);
            end
         end
         if (start && !busy) begin
            quotient_queue.push_back(divide_truncated(req_dividend, req_divisor));
            delta = delta + 1;
         end
         divisions_in_flight <= divisions_in_flight + delta;
      end
   end

   // watchdog on cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("signed_integer_divider: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int unsigned phase_idle[PhaseCount];
      int          per_phase;
      word_type    a;
      word_type    b;
      phase_idle = '{74, 0, 16, 74};
      per_phase = RandomDivisions / PhaseCount;

      // directed: boundaries, signs, zero divisor and overflow
      add_division(ZeroWord, word_type'(1), 0, 1'b0);
      add_division(word_type'(1), word_type'(1), 0, 1'b0);
      add_division(AllOnes, word_type'(1), 0, 1'b0);
      add_division(MaxValue, word_type'(1), 0, 1'b0);
      add_division(MinValue, word_type'(1), 0, 1'b0);
      add_division(MinValue, AllOnes, 0, 1'b0);
      add_division(word_type'(5), ZeroWord, 0, 1'b0);
      add_division(MinValue, ZeroWord, 0, 1'b0);
      add_division(ZeroWord, ZeroWord, 0, 1'b0);
      add_division(AllOnes, ZeroWord, 0, 1'b0);
      add_division(MaxValue, AllOnes, 0, 1'b0);
      add_division(MinValue, MinValue, 0, 1'b0);
      add_division(MaxValue, MaxValue, 0, 1'b0);
      add_division(MinValue, MaxValue, 0, 1'b0);
      add_division(MaxValue, MinValue, 0, 1'b0);
      add_division(word_type'(7), word_type'(2), 0, 1'b0);
      add_division(ZeroWord - 7, word_type'(2), 0, 1'b0);
      add_division(word_type'(7), ZeroWord - 2, 0, 1'b0);
      add_division(ZeroWord - 7, ZeroWord - 2, 0, 1'b0);
      add_division(word_type'(1), MinValue, 0, 1'b0);
      add_division(MinValue, word_type'(2), 0, 1'b0);
      add_division(AllOnes, AllOnes, 0, 1'b0);
      add_division(word_type'(3), word_type'(7), 0, 1'b0);

      // random phases, each opening after the pipeline has drained
      for (int p = 0; p < PhaseCount; p++) begin
         for (int i = 0; i < per_phase; i++) begin
            a = random_operand();
            b = random_operand();
            if ($urandom_range(19) == 0) b = ZeroWord;
            if ($urandom_range(39) == 0) begin
               a = MinValue;
               b = AllOnes;
            end
            add_division(a, b, phase_idle[p], i == 0 || $urandom_range(99) == 0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (division_queue.size() != 0 || start || divisions_in_flight != 0);
      repeat (DivLatency + 4) @(negedge clock);

      if (mismatch_count == 0 && quotient_queue.size() == 0)
         $display("signed_integer_divider: match");
      else
         $display("signed_integer_divider: mismatch");
      $finish;
   end

endmodule

/* signed_integer_divider.f */
hdl/sid_pkg.sv
hdl/sid_prep.sv
hdl/sid_stage.sv
hdl/sid_fix.sv
hdl/signed_integer_divider.sv
bench/testbench.sv
